/* hdl/blg_pkg.sv */
// shared types and constants for the battery level gauge
package blg_pkg;

	localparam int VOLT_W  = 16;
	localparam int LEVEL_W = 4;

	// level mapping constants
	localparam logic [LEVEL_W-1:0] TOP_LEVEL  = 4'd9;
	localparam logic [LEVEL_W-1:0] BASE_LEVEL = 4'd2;
	localparam logic [VOLT_W-1:0]  STEP_MV    = 16'd1000;
	// bands above the base level before the cap is reached
	localparam int NUM_STEPS = 7;

	// configuration register indexes
	localparam logic CFG_FULL = 1'b0;
	localparam logic CFG_LOW  = 1'b1;

	localparam logic [VOLT_W-1:0] FULL_RESET_MV = 16'd16000;
	localparam logic [VOLT_W-1:0] LOW_RESET_MV  = 16'd9000;

	// start-up phase of the averaging ring
	typedef enum logic [1:0] {
		PH_EMPTY,
		PH_ONE,
		PH_RUN
	} phase_t;

	// ring stage controls from the pipeline
	typedef struct packed {
		logic rd_en;
		logic consume;
	} ring_ctl_t;

	// level stage load enables
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} lvl_ctl_t;

	// level thresholds
	typedef struct packed {
		logic [VOLT_W-1:0] full_mv;
		logic [VOLT_W-1:0] low_mv;
	} thresh_t;

endpackage

/* hdl/blg_ram.sv */
// generic single-write, single-read ram with registered read data
module blg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 20
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic                                re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/blg_ring.sv */
// sample ring with running sum: read old entry, update sum, write back
module blg_ring
	import blg_pkg::*;
#(
	parameter int AVG_DEPTH = 20
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ring_ctl_t                                ctl,
	input  logic [VOLT_W-1:0]                        voltage,
	output logic [VOLT_W+$clog2(AVG_DEPTH)-1:0]      sum_s2,
	output logic                                     first_s2
);

	localparam int SUM_W  = VOLT_W + $clog2(AVG_DEPTH);
	localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);
	localparam logic [SUM_W-1:0]  DEPTH_K   = SUM_W'(AVG_DEPTH);

	phase_t              phase_q, phase_d;
	logic [SLOT_W-1:0]   slot_q, slot_d, slot_inc;
	logic                wrapped_q, wrapped_d;
	logic [VOLT_W-1:0]   fill_q, fill_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [VOLT_W-1:0]   voltage_s1;
	logic                fwd_s1;
	logic [VOLT_W-1:0]   fwd_data_s1;
	logic [VOLT_W-1:0]   rd_data;
	logic [VOLT_W-1:0]   old_val;
	logic                fill_sel;
	logic                ram_we;

	blg_ram #(
		.WIDTH(VOLT_W),
		.DEPTH(AVG_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(voltage_s1),
		.re   (ctl.rd_en),
		.raddr(slot_d),
		.rdata(rd_data)
	);

	// phase next state
	always_comb begin
		phase_d = phase_q;
		if (ctl.consume) begin
			unique case (phase_q)
				PH_EMPTY: phase_d = PH_ONE;
				PH_ONE:   phase_d = PH_RUN;
				PH_RUN:   phase_d = PH_RUN;
				default:  phase_d = PH_EMPTY;
			endcase
		end
	end

	// phase outputs: the first two items refill the whole ring
	always_comb begin
		unique case (phase_q)
			PH_EMPTY: fill_sel = 1'b1;
			PH_ONE:   fill_sel = 1'b1;
			PH_RUN:   fill_sel = 1'b0;
			default:  fill_sel = 1'b1;
		endcase
	end

	// entries not yet overwritten since the last fill hold the fill value
	assign old_val  = wrapped_q ? (fwd_s1 ? fwd_data_s1 : rd_data) : fill_q;
	assign slot_inc = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign ram_we   = ctl.consume && !fill_sel;

	// ring bookkeeping and running sum
	always_comb begin
		slot_d    = slot_q;
		wrapped_d = wrapped_q;
		fill_d    = fill_q;
		sum_d     = sum_q;
		if (ctl.consume) begin
			if (fill_sel) begin
				slot_d    = '0;
				wrapped_d = 1'b0;
				fill_d    = voltage_s1;
				sum_d     = SUM_W'(voltage_s1) * DEPTH_K;
			end else begin
				slot_d    = slot_inc;
				wrapped_d = wrapped_q || (slot_q == LAST_SLOT);
				sum_d     = sum_q - SUM_W'(old_val) + SUM_W'(voltage_s1);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_EMPTY;
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			slot_q    <= slot_d;
			wrapped_q <= wrapped_d;
			sum_q     <= sum_d;
		end
	end

	// fill value
	always_ff @(posedge clk) begin
		fill_q <= fill_d;
	end

	// stage 1: item waiting for its ring read, forward a same-edge write
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			voltage_s1  <= voltage;
			fwd_s1      <= ram_we && (slot_q == slot_d);
			fwd_data_s1 <= voltage_s1;
		end
	end

	// stage 2: updated sum
	always_ff @(posedge clk) begin
		if (ctl.consume) begin
			sum_s2   <= sum_d;
			first_s2 <= (phase_q == PH_EMPTY);
		end
	end

endmodule

/* hdl/blg_level.sv */
// average by reciprocal multiply and mapping to a target level
module blg_level
	import blg_pkg::*;
#(
	parameter int AVG_DEPTH = 20
) (
	input  logic                                 clk,
	input  lvl_ctl_t                             ctl,
	input  thresh_t                              thresh,
	input  logic [VOLT_W+$clog2(AVG_DEPTH)-1:0]  sum_s2,
	input  logic                                 first_s2,
	output logic [LEVEL_W-1:0]                   target_s5,
	output logic                                 first_s5
);

	localparam int SUM_W  = VOLT_W + $clog2(AVG_DEPTH);
	localparam int PROD_W = 2 * SUM_W + 1;
	localparam logic [SUM_W:0]   RECIP   = (SUM_W+1)'((64'd1 << SUM_W) / AVG_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_K = SUM_W'(AVG_DEPTH);

	logic [PROD_W-1:0]  prod;
	logic [VOLT_W-1:0]  q_est_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic               first_s3;
	logic [SUM_W-1:0]   rem;
	logic [VOLT_W-1:0]  avg_s4;
	logic               first_s4;
	logic [VOLT_W-1:0]  diff;
	logic [LEVEL_W-1:0] steps;
	logic [LEVEL_W-1:0] target;

	// quotient estimate, low by at most one
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			q_est_s3 <= prod[SUM_W +: VOLT_W];
			sum_s3   <= sum_s2;
			first_s3 <= first_s2;
		end
	end

	// remainder correction
	assign rem = sum_s3 - SUM_W'(q_est_s3) * DEPTH_K;

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			avg_s4   <= (rem >= DEPTH_K) ? q_est_s3 + 1'b1 : q_est_s3;
			first_s4 <= first_s3;
		end
	end

	// count the 1000 mv bands above the low threshold
	assign diff = avg_s4 - thresh.low_mv;

	always_comb begin
		steps = '0;
		for (int k = 1; k <= NUM_STEPS; k++) begin
			if (diff >= VOLT_W'(k * STEP_MV)) begin
				steps = steps + 1'b1;
			end
		end
	end

	// full test first, then the banded range
	always_comb begin
		priority if (avg_s4 >= thresh.full_mv) begin
			target = TOP_LEVEL;
		end else if (avg_s4 >= thresh.low_mv) begin
			target = BASE_LEVEL + steps;
		end else begin
			target = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			target_s5 <= target;
			first_s5  <= first_s4;
		end
	end

endmodule

/* hdl/battery_level_gauge.sv */
// top level of the battery level gauge: pipeline control, config and shown level
//
// Battery level gauge. Each accepted voltage_mv item enters a moving average
// over AVG_DEPTH samples; the average is mapped to a level (0, or 2 to 9 against
// the full_level_mv and low_level_mv thresholds) and the shown level follows it
// by at most one step per item, except that the very first item sets it
// directly. Every item gives one result (shown_level, low_warning). The block
// takes one item per clock unless level_stall holds the pipeline: the ring is a
// single ram with one read and one write each cycle, and the running sum is one
// add and subtract per item. Results pass ring read, sum update, reciprocal
// multiply, remainder correction, level mapping, output register. Config writes
// through cfg_we/cfg_index/cfg_data should be made while no items are in flight.
module battery_level_gauge
	import blg_pkg::*;
#(
	parameter int AVG_DEPTH = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [VOLT_W-1:0]   cfg_data,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [VOLT_W-1:0]   voltage_mv,
	output logic                level_valid,
	input  logic                level_stall,
	output logic [LEVEL_W-1:0]  shown_level,
	output logic                low_warning
);

	localparam int SUM_W = VOLT_W + $clog2(AVG_DEPTH);

	thresh_t              thresh_q;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                 out_valid_q;
	logic                 out_ready;
	logic                 rdy1, rdy2, rdy3, rdy4, rdy5;
	logic                 mv1, mv2, mv3, mv4, mv5;
	logic                 accept;
	ring_ctl_t            ring_ctl;
	lvl_ctl_t             lvl_ctl;
	logic [SUM_W-1:0]     sum_s2;
	logic                 first_s2;
	logic [LEVEL_W-1:0]   target_s5;
	logic                 first_s5;
	logic [LEVEL_W-1:0]   level_q, level_d;
	logic                 warn_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.full_mv <= FULL_RESET_MV;
			thresh_q.low_mv  <= LOW_RESET_MV;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FULL: thresh_q.full_mv <= cfg_data;
				CFG_LOW:  thresh_q.low_mv  <= cfg_data;
				default:  thresh_q.full_mv <= thresh_q.full_mv;
			endcase
		end
	end

	// stage handshake: a stage moves when the next one is free or moving
	assign out_ready = !out_valid_q || !level_stall;
	assign mv5  = valid_s5 && out_ready;
	assign rdy5 = !valid_s5 || out_ready;
	assign mv4  = valid_s4 && rdy5;
	assign rdy4 = !valid_s4 || rdy5;
	assign mv3  = valid_s3 && rdy4;
	assign rdy3 = !valid_s3 || rdy4;
	assign mv2  = valid_s2 && rdy3;
	assign rdy2 = !valid_s2 || rdy3;
	assign mv1  = valid_s1 && rdy2;
	assign rdy1 = !valid_s1 || rdy2;

	assign accept       = sample_valid && rdy1;
	assign sample_stall = !rdy1;

	assign ring_ctl.rd_en   = accept;
	assign ring_ctl.consume = mv1;
	assign lvl_ctl.ld_s3    = mv2;
	assign lvl_ctl.ld_s4    = mv3;
	assign lvl_ctl.ld_s5    = mv4;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !mv1);
			valid_s2 <= mv1 || (valid_s2 && !mv2);
			valid_s3 <= mv2 || (valid_s3 && !mv3);
			valid_s4 <= mv3 || (valid_s4 && !mv4);
			valid_s5 <= mv4 || (valid_s5 && !mv5);
		end
	end

	blg_ring #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.voltage (voltage_mv),
		.sum_s2  (sum_s2),
		.first_s2(first_s2)
	);

	blg_level #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_level (
		.clk      (clk),
		.ctl      (lvl_ctl),
		.thresh   (thresh_q),
		.sum_s2   (sum_s2),
		.first_s2 (first_s2),
		.target_s5(target_s5),
		.first_s5 (first_s5)
	);

	// shown level steps toward the target, first item jumps
	always_comb begin
		priority if (first_s5) begin
			level_d = target_s5;
		end else if (level_q < target_s5) begin
			level_d = level_q + 1'b1;
		end else if (level_q > target_s5) begin
			level_d = level_q - 1'b1;
		end else begin
			level_d = level_q;
		end
	end

	// output register and lagged level state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			level_q     <= '0;
			warn_q      <= 1'b0;
		end else if (mv5) begin
			out_valid_q <= 1'b1;
			level_q     <= level_d;
			warn_q      <= (level_d == '0);
		end else if (!level_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign level_valid = out_valid_q;
	assign shown_level = level_q;
	assign low_warning = warn_q;

	// warning follows the shown level
	a_warn_match: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid |-> (low_warning == (shown_level == '0)))
		else $error("low warning does not match shown level");

	// shown level stays within the display range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid |-> (shown_level <= TOP_LEVEL))
		else $error("shown level above top level");

	// a stalled input means stages one, two and five and the output register hold items
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && valid_s2 && valid_s5 && out_valid_q))
		else $error("input stalled with room in the pipeline");

endmodule

/* bench/tb_battery_level_gauge.sv */
// self-checking testbench for the battery level gauge with a moving-average level predictor
module tb_battery_level_gauge
	import blg_pkg::*;
();

	localparam int AVG_DEPTH      = 20;
	localparam int ITEMS_PER_SET  = 190;
	localparam int NUM_SETS       = 8;
	localparam int DRAIN_CYCLES   = 12;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               warn;
	} gauge_result_t;

	// moving-average level predictor and queue of expected levels
	class level_tracker;
		logic [VOLT_W-1:0]  full_mv;
		logic [VOLT_W-1:0]  low_mv;
		logic [VOLT_W-1:0]  ring [AVG_DEPTH];
		logic [20:0]        volt_sum;
		int unsigned        slot;
		phase_t             phase;
		logic [LEVEL_W-1:0] shown;
		gauge_result_t      expected_levels [$];
		int                 errors;

		function new();
			full_mv  = FULL_RESET_MV;
			low_mv   = LOW_RESET_MV;
			volt_sum = '0;
			slot     = 0;
			phase    = PH_EMPTY;
			shown    = '0;
			errors   = 0;
		endfunction

		function void set_threshold(logic idx, logic [VOLT_W-1:0] val);
			if (idx == CFG_FULL) begin
				full_mv = val;
			end else begin
				low_mv = val;
			end
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%s", msg);
			end
		endfunction

		// full test first, then the low band, capped at the top level
		function logic [LEVEL_W-1:0] band_level(logic [VOLT_W-1:0] mv);
			int unsigned bands;
			if (mv >= full_mv) begin
				return TOP_LEVEL;
			end
			if (mv < low_mv) begin
				return '0;
			end
			bands = (mv - low_mv) / STEP_MV;
			if (bands >= int'(TOP_LEVEL - BASE_LEVEL)) begin
				return TOP_LEVEL;
			end
			return BASE_LEVEL + bands[LEVEL_W-1:0];
		endfunction

		function void fill_ring(logic [VOLT_W-1:0] v);
			foreach (ring[i]) begin
				ring[i] = v;
			end
			volt_sum = 21'(v) * 21'(AVG_DEPTH);
		endfunction

		// one accepted voltage item gives one expected level
		function void note_sample(logic [VOLT_W-1:0] v);
			logic [LEVEL_W-1:0] target;
			logic [VOLT_W-1:0]  avg;
			case (phase)
				PH_EMPTY: begin
					fill_ring(v);
					shown = band_level(v);
					phase = PH_ONE;
				end
				PH_ONE: begin
					fill_ring(v);
					phase = PH_RUN;
				end
				default: begin
					volt_sum = volt_sum - 21'(ring[slot]) + 21'(v);
					ring[slot] = v;
					slot = (slot == AVG_DEPTH - 1) ? 0 : slot + 1;
				end
			endcase
			avg = VOLT_W'(volt_sum / AVG_DEPTH);
			target = band_level(avg);
			if (shown < target) begin
				shown = shown + 1'b1;
			end else if (shown > target) begin
				shown = shown - 1'b1;
			end
			expected_levels.push_back('{level: shown, warn: (shown == '0)});
		endfunction

		function void check_level(logic [LEVEL_W-1:0] lvl, logic warn);
			gauge_result_t exp_r;
			if (expected_levels.size() == 0) begin
				note_error($sformatf("unexpected level item: level %0d warn %0b", lvl, warn));
				return;
			end
			exp_r = expected_levels.pop_front();
			if (lvl !== exp_r.level || warn !== exp_r.warn) begin
				note_error($sformatf("level mismatch: expected level %0d warn %0b, got level %0d warn %0b",
					exp_r.level, exp_r.warn, lvl, warn));
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic                cfg_index    = CFG_FULL;
	logic [VOLT_W-1:0]   cfg_data     = '0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	logic [VOLT_W-1:0]   voltage_mv   = '0;
	logic                level_valid;
	logic                level_stall  = 1'b0;
	logic [LEVEL_W-1:0]  shown_level;
	logic                low_warning;

	level_tracker gauge;
	logic [VOLT_W-1:0] cur_full = FULL_RESET_MV;
	logic [VOLT_W-1:0] cur_low  = LOW_RESET_MV;
	int walk_mv     = 12000;
	int burst_left  = 0;
	int cycle_count = 0;

	battery_level_gauge #(
		.AVG_DEPTH(AVG_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.voltage_mv(voltage_mv),
		.level_valid(level_valid),
		.level_stall(level_stall),
		.shown_level(shown_level),
		.low_warning(low_warning)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// sender bursts: zero gap inside a burst, random gap between bursts
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
	endfunction

	// mostly a slow random walk around the thresholds, plus full-range and edge values
	function automatic logic [VOLT_W-1:0] next_voltage();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			return VOLT_W'($urandom_range(0, 65535));
		end
		if (pick < 14) begin
			case ($urandom_range(0, 5))
				0: return '0;
				1: return '1;
				2: return cur_full;
				3: return cur_full - 1'b1;
				4: return cur_low;
				default: return cur_low - 1'b1;
			endcase
		end
		if ($urandom_range(0, 39) == 0) begin
			walk_mv = ($urandom_range(0, 1) == 0) ? int'(cur_low) : int'(cur_full);
			walk_mv = walk_mv + int'($urandom_range(0, 6000)) - 3000;
		end
		walk_mv = walk_mv + int'($urandom_range(0, 1200)) - 600;
		if (walk_mv < 0) walk_mv = 0;
		if (walk_mv > 65535) walk_mv = 65535;
		return walk_mv[VOLT_W-1:0];
	endfunction

	// offer one voltage item and wait until it is taken
	task automatic send_sample(input logic [VOLT_W-1:0] v, input int gap);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		voltage_mv   <= v;
		do begin
			@(posedge clk);
		end while (sample_stall);
		gauge.note_sample(v);
	endtask

	// hold the sender until every expected level has come out
	task automatic pause_until_drained();
		sample_valid <= 1'b0;
		while (gauge.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// write both thresholds while idle
	task automatic set_thresholds(input logic [VOLT_W-1:0] full_v, input logic [VOLT_W-1:0] low_v);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FULL;
		cfg_data  <= full_v;
		@(posedge clk);
		gauge.set_threshold(CFG_FULL, full_v);
		cur_full   = full_v;
		cfg_index <= CFG_LOW;
		cfg_data  <= low_v;
		@(posedge clk);
		gauge.set_threshold(CFG_LOW, low_v);
		cur_low    = low_v;
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: stall modes of none, random, and long runs
	initial begin
		int  stall_mode;
		int  mode_left;
		int  run_left;
		bit  run_stalled;
		stall_mode  = 0;
		mode_left   = 100;
		run_left    = 0;
		run_stalled = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && level_valid && !level_stall) begin
				gauge.check_level(shown_level, low_warning);
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(50, 300);
				run_left   = 0;
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: level_stall <= 1'b0;
				1: level_stall <= ($urandom_range(0, 99) < 40);
				default: begin
					if (run_left == 0) begin
						run_stalled = !run_stalled;
						run_left = run_stalled ? $urandom_range(1, 20) : $urandom_range(1, 10);
					end
					run_left--;
					level_stall <= run_stalled;
				end
			endcase
		end
	end

	// main stimulus
	initial begin
		logic [VOLT_W-1:0] full_v;
		logic [VOLT_W-1:0] low_v;
		gauge = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: first sample sets the level, second refills the ring
		send_sample(16'd12000, next_gap());
		send_sample(16'hFFFF, next_gap());
		send_sample(16'd0, next_gap());
		send_sample(16'd0, next_gap());
		send_sample(16'hFFFF, next_gap());
		send_sample(16'd16000, next_gap());
		send_sample(16'd15999, next_gap());
		send_sample(16'd9000, next_gap());
		send_sample(16'd8999, next_gap());
		send_sample(16'd9999, next_gap());
		send_sample(16'd10000, next_gap());

		// low threshold above full threshold
		pause_until_drained();
		set_thresholds(16'd8000, 16'd12000);
		send_sample(16'd8000, next_gap());
		send_sample(16'd7999, next_gap());
		send_sample(16'd11000, next_gap());
		send_sample(16'd12500, next_gap());

		// very wide band saturates at the top level
		pause_until_drained();
		set_thresholds(16'hFFFF, 16'd0);
		send_sample(16'hFFFE, next_gap());
		send_sample(16'd30000, next_gap());
		send_sample(16'd7000, next_gap());
		send_sample(16'd0, next_gap());

		// threshold sets: reset and extreme values first, then random ones
		for (int set_i = 0; set_i < NUM_SETS; set_i++) begin
			pause_until_drained();
			case (set_i)
				0: begin full_v = FULL_RESET_MV; low_v = LOW_RESET_MV; end
				1: begin full_v = 16'hFFFF;      low_v = 16'd0;        end
				2: begin full_v = 16'd0;         low_v = 16'hFFFF;     end
				3: begin full_v = 16'hFFFF;      low_v = 16'hFFFF;     end
				4: begin full_v = 16'd0;         low_v = 16'd0;        end
				default: begin
					case ($urandom_range(0, 2))
						0: begin
							low_v  = VOLT_W'($urandom_range(0, 50000));
							full_v = VOLT_W'(int'(low_v) + $urandom_range(0, 15000));
						end
						1: begin
							full_v = VOLT_W'($urandom_range(0, 40000));
							low_v  = VOLT_W'(int'(full_v) + $urandom_range(1, 20000));
						end
						default: begin
							low_v  = VOLT_W'($urandom_range(0, 5000));
							full_v = VOLT_W'($urandom_range(20000, 65535));
						end
					endcase
				end
			endcase
			set_thresholds(full_v, low_v);
			walk_mv = (int'(full_v) + int'(low_v)) / 2;
			repeat (ITEMS_PER_SET) send_sample(next_voltage(), next_gap());
		end

		// drain and report
		sample_valid <= 1'b0;
		while (gauge.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (gauge.pending() != 0) begin
			gauge.note_error($sformatf("%0d expected levels never came out", gauge.pending()));
		end
		if (gauge.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
